/* design/segint_pkg.sv */
// Shared widths and pipeline stage types for the segment intersection test.
package segint_pkg;

   // Coordinate width; differences gain one bit, products double that.
   localparam int COORD_WIDTH = 32;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [CROSS_WIDTH-1:0] cross_type;

   // Stage 1: edge vectors, endpoint offsets and bounding box hits.
   typedef struct packed {
      diff_type   dax;     // a_end - a_start, x
      diff_type   day;     // a_end - a_start, y
      diff_type   dbx;     // b_end - b_start, x
      diff_type   dby;     // b_end - b_start, y
      diff_type   b0ax;    // b_start - a_start
      diff_type   b0ay;
      diff_type   b1ax;    // b_end - a_start
      diff_type   b1ay;
      diff_type   a0bx;    // a_start - b_start
      diff_type   a0by;
      diff_type   a1bx;    // a_end - b_start
      diff_type   a1by;
      logic [3:0] in_box;  // endpoint inside the other segment's box, per orientation
   } stage1_type;

   // Stage 2: the two products of each cross product.
   typedef struct packed {
      prod_type   p1l;
      prod_type   p1r;
      prod_type   p2l;
      prod_type   p2r;
      prod_type   p3l;
      prod_type   p3r;
      prod_type   p4l;
      prod_type   p4r;
      logic [3:0] in_box;
   } stage2_type;

   // Stage 3: sign of each orientation.
   typedef struct packed {
      logic [3:0] neg;
      logic [3:0] zero;
      logic [3:0] in_box;
   } stage3_type;

endpackage

/* design/segment_intersection_test.sv */
// Four-stage pipelined closed line segment intersection test.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------
//   req     | in        | req_valid/req_stall | a_/b_ start/end x/y coordinates
//   rsp     | out       | rsp_valid/rsp_stall | intersects
//
// One beat in and one beat out per cycle while rsp is not stalled; an accepted beat
// passes through the four registered stages in order before rsp_valid rises:
// differences, multipliers, cross product subtract, final combine.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse and a stall on rsp holds each occupied stage with no bubble after it, without loss.
// Reset (synchronous) clears the stage valid bits only.
module segment_intersection_test (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [segint_pkg::COORD_WIDTH-1:0] req_a_start_x,
   input  logic [segint_pkg::COORD_WIDTH-1:0] req_a_start_y,
   input  logic [segint_pkg::COORD_WIDTH-1:0] req_a_end_x,
   input  logic [segint_pkg::COORD_WIDTH-1:0] req_a_end_y,
   input  logic [segint_pkg::COORD_WIDTH-1:0] req_b_start_x,
   input  logic [segint_pkg::COORD_WIDTH-1:0] req_b_start_y,
   input  logic [segint_pkg::COORD_WIDTH-1:0] req_b_end_x,
   input  logic [segint_pkg::COORD_WIDTH-1:0] req_b_end_y,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_intersects
);

   segint_pkg::coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

   segint_pkg::stage1_type s1_in, s1_ff;
   segint_pkg::stage2_type s2_in, s2_ff;
   segint_pkg::stage3_type s3_in, s3_ff;
   logic                   hit_in, hit_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   // Stage advance chain
   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall      = !en1;
   assign rsp_valid      = v4_ff;
   assign rsp_intersects = hit_ff;

   assign ax0 = segint_pkg::coord_type'(req_a_start_x);
   assign ay0 = segint_pkg::coord_type'(req_a_start_y);
   assign ax1 = segint_pkg::coord_type'(req_a_end_x);
   assign ay1 = segint_pkg::coord_type'(req_a_end_y);
   assign bx0 = segint_pkg::coord_type'(req_b_start_x);
   assign by0 = segint_pkg::coord_type'(req_b_start_y);
   assign bx1 = segint_pkg::coord_type'(req_b_end_x);
   assign by1 = segint_pkg::coord_type'(req_b_end_y);

   // Stage 1: differences at one extra bit, box checks on the raw coordinates
   always_comb begin
      s1_in.dax  = segint_pkg::diff_type'(ax1) - segint_pkg::diff_type'(ax0);
      s1_in.day  = segint_pkg::diff_type'(ay1) - segint_pkg::diff_type'(ay0);
      s1_in.dbx  = segint_pkg::diff_type'(bx1) - segint_pkg::diff_type'(bx0);
      s1_in.dby  = segint_pkg::diff_type'(by1) - segint_pkg::diff_type'(by0);
      s1_in.b0ax = segint_pkg::diff_type'(bx0) - segint_pkg::diff_type'(ax0);
      s1_in.b0ay = segint_pkg::diff_type'(by0) - segint_pkg::diff_type'(ay0);
      s1_in.b1ax = segint_pkg::diff_type'(bx1) - segint_pkg::diff_type'(ax0);
      s1_in.b1ay = segint_pkg::diff_type'(by1) - segint_pkg::diff_type'(ay0);
      s1_in.a0bx = segint_pkg::diff_type'(ax0) - segint_pkg::diff_type'(bx0);
      s1_in.a0by = segint_pkg::diff_type'(ay0) - segint_pkg::diff_type'(by0);
      s1_in.a1bx = segint_pkg::diff_type'(ax1) - segint_pkg::diff_type'(bx0);
      s1_in.a1by = segint_pkg::diff_type'(ay1) - segint_pkg::diff_type'(by0);
      // r in box(p,q): r is above one bound and below one bound on each axis
      s1_in.in_box[0] = (bx0 >= ax0 || bx0 >= ax1) && (bx0 <= ax0 || bx0 <= ax1) &&
                        (by0 >= ay0 || by0 >= ay1) && (by0 <= ay0 || by0 <= ay1);
      s1_in.in_box[1] = (bx1 >= ax0 || bx1 >= ax1) && (bx1 <= ax0 || bx1 <= ax1) &&
                        (by1 >= ay0 || by1 >= ay1) && (by1 <= ay0 || by1 <= ay1);
      s1_in.in_box[2] = (ax0 >= bx0 || ax0 >= bx1) && (ax0 <= bx0 || ax0 <= bx1) &&
                        (ay0 >= by0 || ay0 >= by1) && (ay0 <= by0 || ay0 <= by1);
      s1_in.in_box[3] = (ax1 >= bx0 || ax1 >= bx1) && (ax1 <= bx0 || ax1 <= bx1) &&
                        (ay1 >= by0 || ay1 >= by1) && (ay1 <= by0 || ay1 <= by1);
   end

   // Stage 2: one multiplier per product term
   always_comb begin
      s2_in.p1l    = s1_ff.dax * s1_ff.b0ay;
      s2_in.p1r    = s1_ff.b0ax * s1_ff.day;
      s2_in.p2l    = s1_ff.dax * s1_ff.b1ay;
      s2_in.p2r    = s1_ff.b1ax * s1_ff.day;
      s2_in.p3l    = s1_ff.dbx * s1_ff.a0by;
      s2_in.p3r    = s1_ff.a0bx * s1_ff.dby;
      s2_in.p4l    = s1_ff.dbx * s1_ff.a1by;
      s2_in.p4r    = s1_ff.a1bx * s1_ff.dby;
      s2_in.in_box = s1_ff.in_box;
   end

   // Stage 3: exact cross products, keep only the sign
   segint_pkg::cross_type c1, c2, c3, c4;
   always_comb begin
      c1 = segint_pkg::cross_type'(s2_ff.p1l) - segint_pkg::cross_type'(s2_ff.p1r);
      c2 = segint_pkg::cross_type'(s2_ff.p2l) - segint_pkg::cross_type'(s2_ff.p2r);
      c3 = segint_pkg::cross_type'(s2_ff.p3l) - segint_pkg::cross_type'(s2_ff.p3r);
      c4 = segint_pkg::cross_type'(s2_ff.p4l) - segint_pkg::cross_type'(s2_ff.p4r);
      s3_in.neg    = {c4[segint_pkg::CROSS_WIDTH-1], c3[segint_pkg::CROSS_WIDTH-1],
                      c2[segint_pkg::CROSS_WIDTH-1], c1[segint_pkg::CROSS_WIDTH-1]};
      s3_in.zero   = {c4 == '0, c3 == '0, c2 == '0, c1 == '0};
      s3_in.in_box = s2_ff.in_box;
   end

   // Stage 4: proper crossing, or a collinear endpoint inside the other box
   logic cross_a, cross_b;
   always_comb begin
      cross_a = !s3_ff.zero[0] && !s3_ff.zero[1] && (s3_ff.neg[0] != s3_ff.neg[1]);
      cross_b = !s3_ff.zero[2] && !s3_ff.zero[3] && (s3_ff.neg[2] != s3_ff.neg[3]);
      hit_in  = (cross_a && cross_b) || ((s3_ff.zero & s3_ff.in_box) != '0);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Stage payloads, no reset
   always_ff @(posedge clock) begin
      if (en1) s1_ff  <= s1_in;
      if (en2) s2_ff  <= s2_in;
      if (en3) s3_ff  <= s3_in;
      if (en4) hit_ff <= hit_in;
   end

endmodule

/* design/segint_checker.sv */
// Port-level checker for the segment intersection test, bound to the top level.
module segint_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_intersects
);

   // Input backpressure only when every stage is full and the output is stalled
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled full output");

   // After a reset cycle, nothing reaches the output before a new beat has passed every stage
   a_reset_latency: assert property (@(posedge clock)
      reset |=> !rsp_valid [*3])
      else $error("rsp beat too soon after reset");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_intersects))
      else $error("stalled rsp beat changed");

endmodule

bind segment_intersection_test segint_checker u_segint_checker (.*);
